[rtl/core/aws_pkg.sv]
// ----------------------------------------------------------------------------
// Ascending word sorter package
// Shared word width and the control bundle that the top level broadcasts to
// every cell of the insertion chain.
// ----------------------------------------------------------------------------
package aws_pkg;

    localparam int WORD_W = 16;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  ins;
        logic  shift;
        word_t word;
    } cell_ctrl_t;

endpackage

[rtl/core/aws_cell.sv]
// ----------------------------------------------------------------------------
// Ascending word sorter cell
// One slot of the insertion chain. It holds a word in sorted position and a
// word in arrival position, takes its left neighbor's word when a smaller new
// word pushes the row right, and takes its right neighbor's words while the
// row drains toward the output.
// ----------------------------------------------------------------------------
module aws_cell
    import aws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       prev_take,
    input  logic       prev_valid,
    input  word_t      prev_sval,
    input  logic       next_valid,
    input  word_t      next_sval,
    input  word_t      next_aval,
    output logic       take,
    output logic       valid,
    output word_t      sval,
    output word_t      aval
);

    logic  valid_reg;
    word_t sval_reg;
    word_t aval_reg;

    assign take  = !valid_reg || (sval_reg > ctrl.word);
    assign valid = valid_reg;
    assign sval  = sval_reg;
    assign aval  = aval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.ins)
        begin
            valid_reg <= valid_reg | prev_valid;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= next_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            if (take)
            begin
                sval_reg <= prev_take ? prev_sval : ctrl.word;
            end
            if (!valid_reg)
            begin
                aval_reg <= ctrl.word;
            end
        end
        else if (ctrl.shift)
        begin
            sval_reg <= next_sval;
            aval_reg <= next_aval;
        end
    end

endmodule

[rtl/core/ascending_word_sorter_unit.sv]
// ----------------------------------------------------------------------------
// Ascending word sorter
// Collects a run of 16-bit words and returns them in ascending order, or in
// arrival order when sorting is disabled.
// ----------------------------------------------------------------------------
// Words enter on the s_ channel, one transaction per word, the last word of a
// run marked by s_tlast. Each word is inserted into a row of MAX_ELEMENTS
// cells as it arrives, so a run loads at one word per cycle. Words that arrive
// while all cells are occupied are dropped and the run is flagged.
// The cycle after the last word is accepted, the first result is offered on
// the m_ channel. The row then drains one word per accepted transaction from
// cell 0; s_tready stays low until the final result (m_tlast) is taken.
// m_tuser is the overflow flag and is the same on every result of the run.
// While the receiver holds m_tready low the row keeps its contents and the
// offered result is unchanged.
// cfg_data writes the sort enable (1 sorts, 0 keeps arrival order); the value
// held when the last word arrives applies to that run. cfg_ready is always
// high. Reset empties the row, clears the overflow flag and sets sort enable.
// ----------------------------------------------------------------------------
module ascending_word_sorter_unit
    import aws_pkg::*;
#(
    parameter int MAX_ELEMENTS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_data,   // sort_enable
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,    // word_value
    input  logic              s_tlast,    // is_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,    // sorted_value
    output logic              m_tlast,    // is_final
    output logic [0:0]        m_tuser     // overflowed
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic       state_reg;
    logic       state_next;
    logic       sort_en_reg;
    logic       mode_reg;
    logic       ovf_reg;
    logic       ovf_next;
    logic       in_fire;
    logic       out_fire;
    cell_ctrl_t ctrl;

    logic [MAX_ELEMENTS-1:0] take;
    logic [MAX_ELEMENTS-1:0] valid;
    word_t                   sval [MAX_ELEMENTS];
    word_t                   aval [MAX_ELEMENTS];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_LOAD);
    assign m_tvalid  = (state_reg == ST_DRAIN);
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;

    assign ctrl.ins   = in_fire && !valid[MAX_ELEMENTS-1];
    assign ctrl.shift = out_fire;
    assign ctrl.word  = s_tdata;

    assign m_tdata    = mode_reg ? sval[0] : aval[0];
    assign m_tlast    = !valid[1];
    assign m_tuser    = ovf_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++)
        begin : g_cell
            logic  prev_take;
            logic  prev_valid;
            word_t prev_sval;
            logic  next_valid;
            word_t next_sval;
            word_t next_aval;

            if (gi == 0)
            begin : g_head
                assign prev_take  = 1'b0;
                assign prev_valid = 1'b1;
                assign prev_sval  = '0;
            end
            else
            begin : g_body
                assign prev_take  = take[gi-1];
                assign prev_valid = valid[gi-1];
                assign prev_sval  = sval[gi-1];
            end

            if (gi == MAX_ELEMENTS - 1)
            begin : g_tail
                assign next_valid = 1'b0;
                assign next_sval  = '0;
                assign next_aval  = '0;
            end
            else
            begin : g_inner
                assign next_valid = valid[gi+1];
                assign next_sval  = sval[gi+1];
                assign next_aval  = aval[gi+1];
            end

            aws_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_take  (prev_take),
                .prev_valid (prev_valid),
                .prev_sval  (prev_sval),
                .next_valid (next_valid),
                .next_sval  (next_sval),
                .next_aval  (next_aval),
                .take       (take[gi]),
                .valid      (valid[gi]),
                .sval       (sval[gi]),
                .aval       (aval[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (valid[MAX_ELEMENTS-1])
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire && m_tlast)
                begin
                    state_next = ST_LOAD;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            ovf_reg     <= 1'b0;
            sort_en_reg <= 1'b1;
            mode_reg    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            if (cfg_valid && cfg_ready)
            begin
                sort_en_reg <= cfg_data[0];
            end
            if (in_fire && s_tlast)
            begin
                mode_reg <= sort_en_reg;
            end
        end
    end

endmodule

[rtl/core/aws_checker.sv]
// ----------------------------------------------------------------------------
// Ascending word sorter checker
// Port-level checks on the load and drain phases, bound to the top level.
// ----------------------------------------------------------------------------
module aws_checker
    import aws_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [WORD_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic [0:0]        m_tuser
);

    // Loading and draining never overlap.
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while results are pending");

    // The last word of a run starts the drain in the next cycle.
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after the last word");

    // Taking the final result returns the block to loading.
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("block did not return to loading");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // The overflow flag is the same on every result of a run.
    a_ovf_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tuser == $past(m_tuser)))
        else $error("overflow flag changed within a run");

endmodule

bind ascending_word_sorter_unit aws_checker u_aws_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

[tb/ascending_word_sorter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ascending word sorter testbench
// Streams runs of 16-bit words into the sorter and checks every result
// against a built-in insertion-sort predictor. Directed runs cover the value
// extremes, both sort settings and an enable change in the middle of a run.
// Random runs cover short runs, full runs and runs that overflow the store,
// with random idle cycles on both sides and a long receiver stall.
// ----------------------------------------------------------------------------
module ascending_word_sorter_unit_tb;
    import aws_pkg::*;

    localparam int SORT_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        word_t value;
        logic  last;
    } word_item_t;

    typedef struct packed {
        word_t value;
        logic  last;
        logic  overflow;
    } sorted_item_t;

    typedef enum int {
        FLAVOR_DUPES,
        FLAVOR_EXTREMES,
        FLAVOR_MIDSCALE,
        FLAVOR_ANY
    } value_flavor_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_data  = 1'b1;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [WORD_W-1:0] m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    word_item_t   pending_words[$];
    sorted_item_t expected_results[$];
    word_t        held_words[SORT_DEPTH];
    int           held_count     = 0;
    logic         run_overflow   = 1'b0;
    logic         sort_on        = 1'b1;
    int           words_queued   = 0;
    int           words_accepted = 0;
    int           error_count    = 0;
    int           cycle_count    = 0;
    int           src_gap        = 0;
    int           sink_gap       = 0;
    logic         bursts_on      = 1'b1;
    logic         sink_hold      = 1'b0;

    ascending_word_sorter_unit #(
        .MAX_ELEMENTS(SORT_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    function automatic void absorb_word(input word_t value, input logic last);
        word_t        ordered[SORT_DEPTH];
        word_t        moving;
        int           j;
        sorted_item_t result;
        if (held_count < SORT_DEPTH)
        begin
            held_words[held_count] = value;
            held_count++;
        end
        else
        begin
            run_overflow = 1'b1;
        end
        if (last)
        begin
            ordered = held_words;
            if (sort_on)
            begin
                for (int i = 1; i < held_count; i++)
                begin
                    moving = ordered[i];
                    j = i;
                    while (j > 0 && ordered[j-1] > moving)
                    begin
                        ordered[j] = ordered[j-1];
                        j--;
                    end
                    ordered[j] = moving;
                end
            end
            for (int k = 0; k < held_count; k++)
            begin
                result.value    = ordered[k];
                result.last     = (k == held_count - 1);
                result.overflow = run_overflow;
                expected_results.push_back(result);
            end
            held_count   = 0;
            run_overflow = 1'b0;
        end
    endfunction

    function automatic word_t pick_word(input value_flavor_t flavor);
        case (flavor)
            FLAVOR_DUPES:
                return word_t'($urandom_range(0, 7));
            FLAVOR_EXTREMES:
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    2:       return 16'h0001;
                    default: return 16'hFFFE;
                endcase
            FLAVOR_MIDSCALE:
                return word_t'(32'h7FF8 + $urandom_range(0, 15));
            default:
                return word_t'($urandom);
        endcase
    endfunction

    task automatic queue_word(input word_t value, input logic last);
        word_item_t item;
        item.value = value;
        item.last  = last;
        pending_words.push_back(item);
        words_queued++;
    endtask

    task automatic queue_random_run(input int len);
        value_flavor_t flavor;
        flavor = value_flavor_t'($urandom_range(0, 3));
        for (int i = 0; i < len; i++)
        begin
            queue_word(pick_word(flavor), i == len - 1);
        end
    endtask

    task automatic queue_random_phase(input int target);
        int queued;
        int len;
        int pick;
        queued = 0;
        while (queued < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 8);
            else if (pick == 1)
                len = $urandom_range(SORT_DEPTH - 1, SORT_DEPTH);
            else
                len = $urandom_range(1, 12);
            queue_random_run(len);
            queued += len;
        end
    endtask

    task automatic wait_until_drained();
        while (words_accepted != words_queued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_sort_enable(input logic value);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sort_on = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_gap = 0;
        end
        else
        begin : drive_step
            logic       next_valid;
            word_item_t next_item;
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                absorb_word(s_tdata, s_tlast);
                words_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                end
                else if (pending_words.size() > 0)
                begin
                    if (bursts_on && $urandom_range(0, 4) == 0)
                    begin
                        src_gap = $urandom_range(0, 5);
                    end
                    else
                    begin
                        next_item = pending_words.pop_front();
                        s_tdata <= next_item.value;
                        s_tlast <= next_item.last;
                        next_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin : sink_step
            sorted_item_t want;
            logic         next_ready;
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: sorted_value %0d", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        $error("sorted_value: expected %0d, actual %0d", want.value, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("is_final: expected %0d, actual %0d", want.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== want.overflow)
                    begin
                        $error("overflowed: expected %0d, actual %0d", want.overflow, m_tuser);
                        error_count++;
                    end
                end
            end
            next_ready = 1'b1;
            if (sink_hold)
            begin
                next_ready = 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                next_ready = 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                sink_gap = $urandom_range(0, 5);
                next_ready = 1'b0;
            end
            m_tready <= next_ready;
        end
    end

    // The receiver stalls long enough for the sender to back up.
    initial
    begin
        while (words_accepted < 60)
            @(negedge clk);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (300) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_word(16'h0000, 1'b1);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h0001, 1'b0);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h7FFF, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'hAAAA, 1'b0);
        queue_word(16'h5555, 1'b1);
        wait_until_drained();

        write_sort_enable(1'b0);
        queue_word(16'd9, 1'b0);
        queue_word(16'd3, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'h0000, 1'b1);

        // The enable value at the last word decides the order of the run.
        queue_word(16'd700, 1'b0);
        queue_word(16'd200, 1'b0);
        queue_word(16'd500, 1'b0);
        wait_until_drained();
        write_sort_enable(1'b1);
        queue_word(16'd100, 1'b1);
        wait_until_drained();

        queue_random_phase(100);
        wait_until_drained();

        write_sort_enable(1'b0);
        queue_random_phase(60);
        wait_until_drained();

        write_sort_enable(1'b1);
        bursts_on = 1'b0;
        queue_random_phase(70);
        wait_until_drained();

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
